@@ rtl/wrbm_pkg.sv @@
// Package for the wildcard rule best-match classifier.
// Holds the rule and match-token types, codes and shared constants.
// No dependencies.
package wrbm_pkg;

	localparam int RULES_DEF = 32;
	localparam int IDX_W     = 5;
	localparam int SCORE_W   = 4;

	localparam logic [7:0]         WILDCARD  = 8'hFF;
	localparam logic [SCORE_W-1:0] ID_WEIGHT = 4'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_MATCH = 1'b1;

	// One rule as it is loaded into a cell.
	typedef struct packed {
		logic        valid;
		logic        match_device;
		logic [23:0] triple;
		logic [15:0] vendor;
		logic [15:0] product;
		logic [15:0] subdev;
	} rule_t;

	// The match token walking down the chain with the best rule so far.
	typedef struct packed {
		logic [23:0]        dev_triple;
		logic [23:0]        if_triple;
		logic [15:0]        dev_vendor;
		logic [15:0]        dev_product;
		logic               found;
		logic [SCORE_W-1:0] score;
		logic [IDX_W-1:0]   index;
		logic [15:0]        subdev;
	} token_t;

endpackage

@@ rtl/wildcard_rule_best_match_classifier.sv @@
// Wildcard rule best-match classifier: a chain of RULES rule cells.
// A match item walks the chain one cell per cycle, then its result goes to the output
// register (via the hold register if the output is not free); no new match or rule write
// is taken until the result has been loaded into the output register.
// Reset clears every rule's valid flag and all handshake state at once.
// Depends on wrbm_pkg and wrbm_cell.
module wildcard_rule_best_match_classifier #(
	parameter int RULES = wrbm_pkg::RULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [4:0]  rule_index,
	input  logic        rule_valid,
	input  logic        rule_match_device,
	input  logic [23:0] rule_triple,
	input  logic [15:0] rule_vendor,
	input  logic [15:0] rule_product,
	input  logic [15:0] rule_subdev,
	input  logic [23:0] dev_triple,
	input  logic [23:0] if_triple,
	input  logic [15:0] dev_vendor,
	input  logic [15:0] dev_product,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic [7:0]  subdev_class_out,
	output logic [7:0]  subdev_subclass_out,
	output logic [3:0]  win_score,
	output logic [4:0]  best_index
);

	logic             busy_q;
	logic             hold_valid_q;
	wrbm_pkg::token_t hold_q;
	logic             out_valid_q;
	wrbm_pkg::token_t out_q;

	logic             accept;
	logic             wr_accept;
	logic             match_accept;
	wrbm_pkg::rule_t  wr_rule;

	logic             chain_valid [RULES+1];
	wrbm_pkg::token_t chain_tok   [RULES+1];

	logic out_free;
	logic load_chain;
	logic load_hold;

	assign in_ready     = !busy_q;
	assign accept       = in_valid && in_ready;
	assign wr_accept    = accept && (operation == wrbm_pkg::OP_WRITE);
	assign match_accept = accept && (operation == wrbm_pkg::OP_MATCH);

	always_comb begin
		wr_rule.valid        = rule_valid;
		wr_rule.match_device = rule_match_device;
		wr_rule.triple       = rule_triple;
		wr_rule.vendor       = rule_vendor;
		wr_rule.product      = rule_product;
		wr_rule.subdev       = rule_subdev;

		chain_valid[0]          = match_accept;
		chain_tok[0].dev_triple  = dev_triple;
		chain_tok[0].if_triple   = if_triple;
		chain_tok[0].dev_vendor  = dev_vendor;
		chain_tok[0].dev_product = dev_product;
		chain_tok[0].found       = 1'b0;
		chain_tok[0].score       = '0;
		chain_tok[0].index       = '0;
		chain_tok[0].subdev      = '0;
	end

	for (genvar i = 0; i < RULES; i++) begin : g_cell
		logic cell_we;
		// Slots past the 5-bit index range are never written and stay invalid.
		assign cell_we = wr_accept && (int'(rule_index) == i);
		wrbm_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.wr_en        (cell_we),
			.wr_rule      (wr_rule),
			.tok_valid_in (chain_valid[i]),
			.tok_in       (chain_tok[i]),
			.tok_valid_out(chain_valid[i+1]),
			.tok_out      (chain_tok[i+1])
		);
	end

	// The finished item goes straight to the output register when it is free,
	// otherwise it parks in the hold register until the result is taken.
	assign out_free   = !out_valid_q || out_ready;
	assign load_chain = chain_valid[RULES] && out_free;
	assign load_hold  = hold_valid_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (match_accept) begin
				busy_q <= 1'b1;
			end else if (load_chain || load_hold) begin
				busy_q <= 1'b0;
			end
			if (chain_valid[RULES] && !out_free) begin
				hold_valid_q <= 1'b1;
			end else if (load_hold) begin
				hold_valid_q <= 1'b0;
			end
			if (load_chain || load_hold) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_valid[RULES] && !out_free) begin
			hold_q <= chain_tok[RULES];
		end
		if (load_hold) begin
			out_q <= hold_q;
		end else if (load_chain) begin
			out_q <= chain_tok[RULES];
		end
	end

	assign out_valid           = out_valid_q;
	assign matched             = out_q.found;
	assign subdev_class_out    = out_q.subdev[15:8];
	assign subdev_subclass_out = out_q.subdev[7:0];
	assign win_score           = out_q.score;
	assign best_index          = out_q.index;

endmodule

@@ rtl/wrbm_cell.sv @@
// One rule slot of the classifier chain: stores a rule and scores the passing item.
// Depends on wrbm_pkg.
module wrbm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  wrbm_pkg::rule_t wr_rule,
	input  logic            tok_valid_in,
	input  wrbm_pkg::token_t tok_in,
	output logic            tok_valid_out,
	output wrbm_pkg::token_t tok_out
);

	localparam logic [wrbm_pkg::IDX_W-1:0] MY_IDX = wrbm_pkg::IDX_W'(CELL_IDX);

	logic            valid_q;
	wrbm_pkg::rule_t rule_q;

	logic [23:0] cand;
	logic [2:0]  byte_ok;
	logic [2:0]  byte_used;
	logic        vendor_used;
	logic        product_used;
	logic        vendor_ok;
	logic        product_ok;
	logic        hit;
	logic [wrbm_pkg::SCORE_W-1:0] score;
	logic        take;
	wrbm_pkg::token_t tok_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= wr_rule.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_q <= wr_rule;
		end
	end

	always_comb begin
		cand = rule_q.match_device ? tok_in.dev_triple : tok_in.if_triple;
		for (int b = 0; b < 3; b++) begin
			byte_used[b] = rule_q.triple[8*b +: 8] != wrbm_pkg::WILDCARD;
			byte_ok[b]   = !byte_used[b] || (rule_q.triple[8*b +: 8] == cand[8*b +: 8]);
		end
		vendor_used  = rule_q.vendor != 16'd0;
		product_used = vendor_used && (rule_q.product != 16'd0);
		// A vendor rule never matches a device with an unknown vendor.
		vendor_ok  = !vendor_used ||
			((tok_in.dev_vendor != 16'd0) && (rule_q.vendor == tok_in.dev_vendor));
		product_ok = !product_used || (rule_q.product == tok_in.dev_product);
		hit = valid_q && (&byte_ok) && vendor_ok && product_ok;
		score = wrbm_pkg::SCORE_W'(byte_used[0]) + wrbm_pkg::SCORE_W'(byte_used[1])
			+ wrbm_pkg::SCORE_W'(byte_used[2])
			+ (vendor_used ? wrbm_pkg::ID_WEIGHT : '0)
			+ (product_used ? wrbm_pkg::ID_WEIGHT : '0);
		// Strictly greater keeps the lowest index on a tie.
		take = hit && (!tok_in.found || (score > tok_in.score));
		tok_next = tok_in;
		if (take) begin
			tok_next.found  = 1'b1;
			tok_next.score  = score;
			tok_next.index  = MY_IDX;
			tok_next.subdev = rule_q.subdev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_out <= 1'b0;
		end else begin
			tok_valid_out <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_out <= tok_next;
	end

endmodule
